// ===== src/table_interp_cosine_macros.svh =====
// Assertion macros for the table-interpolated cosine block.
`ifndef TABLE_INTERP_COSINE_MACROS_SVH
`define TABLE_INTERP_COSINE_MACROS_SVH

// Check that holds at every edge, reset included
`define TIC_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) (expr)) else $error(msg);

// Same-cycle implication, off during reset
`define TIC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset
`define TIC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tic_pkg.sv =====
// Package: widths, fixed-point constants and the quarter-wave sine builder.
`timescale 1ns / 1ps

package tic_pkg;

  localparam int ANGLE_W = 32;
  localparam int COS_W   = 16;
  localparam int PHASE_W = 32;

  localparam int TABLE_SIZE_DEF    = 512;
  localparam int FRACTION_BITS_DEF = 15;

  // round(2^32 / (2*pi)): radians in Q15.16 to turns in Q0.32
  localparam logic [29:0] TURN_SCALE   = 30'd683565276;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;

  localparam logic [15:0] Q15_MAX_POS = 16'd32767;
  localparam logic [15:0] Q15_MAG_MAX = 16'd32768;

  // Magnitude of sin((pi/2) * num / 2^iw) in Q15, rounded half up, capped at 1.0.
  // Q2.30 Taylor series in Horner form, every step truncating. Elaboration only.
  function automatic logic [15:0] qsine_q15(input int unsigned num, input int unsigned iw);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sub;
    logic [63:0] s;
    x = (HALF_PI_Q30 * 64'(num)) >> iw;
    x2 = (x * x) >> 30;
    t = Q30_ONE;
    sub = ((x2 * t) >> 30) / 64'd420;
    t = (sub < Q30_ONE) ? Q30_ONE - sub : '0;
    sub = ((x2 * t) >> 30) / 64'd342;
    t = (sub < Q30_ONE) ? Q30_ONE - sub : '0;
    sub = ((x2 * t) >> 30) / 64'd272;
    t = (sub < Q30_ONE) ? Q30_ONE - sub : '0;
    sub = ((x2 * t) >> 30) / 64'd210;
    t = (sub < Q30_ONE) ? Q30_ONE - sub : '0;
    sub = ((x2 * t) >> 30) / 64'd156;
    t = (sub < Q30_ONE) ? Q30_ONE - sub : '0;
    sub = ((x2 * t) >> 30) / 64'd110;
    t = (sub < Q30_ONE) ? Q30_ONE - sub : '0;
    sub = ((x2 * t) >> 30) / 64'd72;
    t = (sub < Q30_ONE) ? Q30_ONE - sub : '0;
    sub = ((x2 * t) >> 30) / 64'd42;
    t = (sub < Q30_ONE) ? Q30_ONE - sub : '0;
    sub = ((x2 * t) >> 30) / 64'd20;
    t = (sub < Q30_ONE) ? Q30_ONE - sub : '0;
    sub = ((x2 * t) >> 30) / 64'd6;
    t = (sub < Q30_ONE) ? Q30_ONE - sub : '0;
    s = (((x * t) >> 30) + 64'd16384) >> 15;
    if (s > 64'(Q15_MAG_MAX)) begin
      s = 64'(Q15_MAG_MAX);
    end
    return s[15:0];
  endfunction

endpackage

// ===== src/tic_angle_if.sv =====
// Stream interface carrying one angle per transfer.
`timescale 1ns / 1ps

interface tic_angle_if import tic_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle_rad;

  modport source (output valid, output angle_rad, input ready);
  modport sink (input valid, input angle_rad, output ready);
endinterface

// ===== src/tic_cos_if.sv =====
// Stream interface carrying one cosine value per transfer.
`timescale 1ns / 1ps

interface tic_cos_if import tic_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [COS_W-1:0] cos_value;

  modport source (output valid, output cos_value, input ready);
  modport sink (input valid, input cos_value, output ready);
endinterface

// ===== src/table_interp_cosine.sv =====
// Top level of the table-interpolated cosine pipeline.
`timescale 1ns / 1ps
`include "table_interp_cosine_macros.svh"

// Cosine of a Q15.16 angle in radians, returned as Q1.15 (+1.0 reads as 32767).
// The angle is scaled to a wrapping 32-bit phase in turns, so any angle is valid.
// A folded quarter-wave sine table of TABLE_SIZE/4+1 entries, fixed at build time,
// gives two neighboring samples that are linearly interpolated with a FRACTION_BITS
// weight, floored. Five register stages: scale multiply, phase split, table read,
// interpolation multiply, output add. One angle is taken every clock while the
// output is not stalled; each angle passes the stages in that order. The output
// stage is a register, and a stall at the output holds each stage only once it
// is full, so bubbles close up. No clearing pass or warm-up after reset.
module table_interp_cosine import tic_pkg::*; #(
  parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  tic_angle_if.sink   angle,
  tic_cos_if.source   cosine
);

  localparam int IW = $clog2(TABLE_SIZE);

  logic                       ph_valid;
  logic                       ph_ready;
  logic [IW-1:0]              ph_index;
  logic [FRACTION_BITS-1:0]   ph_frac;
  logic                       lk_valid;
  logic                       lk_ready;
  logic signed [COS_W-1:0]    lk_lo;
  logic signed [COS_W-1:0]    lk_hi;
  logic [FRACTION_BITS-1:0]   lk_frac;
  logic                       angle_xfer;

  tic_phase #(
    .TABLE_SIZE    (TABLE_SIZE),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_phase (
    .clk      (clk),
    .rst      (rst),
    .up_valid (angle.valid),
    .up_ready (angle.ready),
    .up_angle (angle.angle_rad),
    .dn_valid (ph_valid),
    .dn_ready (ph_ready),
    .dn_index (ph_index),
    .dn_frac  (ph_frac)
  );

  tic_lookup #(
    .TABLE_SIZE    (TABLE_SIZE),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_lookup (
    .clk      (clk),
    .rst      (rst),
    .up_valid (ph_valid),
    .up_ready (ph_ready),
    .up_index (ph_index),
    .up_frac  (ph_frac),
    .dn_valid (lk_valid),
    .dn_ready (lk_ready),
    .dn_lo    (lk_lo),
    .dn_hi    (lk_hi),
    .dn_frac  (lk_frac)
  );

  tic_interp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_interp (
    .clk      (clk),
    .rst      (rst),
    .up_valid (lk_valid),
    .up_ready (lk_ready),
    .up_lo    (lk_lo),
    .up_hi    (lk_hi),
    .up_frac  (lk_frac),
    .dn_valid (cosine.valid),
    .dn_ready (cosine.ready),
    .dn_cos   (cosine.cos_value)
  );

  assign angle_xfer = angle.valid && angle.ready;

  // Pipeline is empty right after reset
  `TIC_ASSERT_ALWAYS(a_empty_after_rst, rst || !$past(rst) || !cosine.valid, "result valid after reset")
  // A ready sink never backs up the input side
  `TIC_ASSERT_IMP(a_ready_chain, cosine.ready, angle.ready, "input stalled with sink ready")
  // With the sink ready throughout, an accepted angle reaches the output register
  `TIC_ASSERT_NXT(a_latency, angle_xfer ##1 cosine.ready ##1 cosine.ready ##1 cosine.ready ##1 cosine.ready, cosine.valid, "result missing after pipeline latency")

endmodule

// ===== src/tic_phase.sv =====
// Phase stages: radians to wrapped turns, quarter-turn offset, index/fraction split.
`timescale 1ns / 1ps

module tic_phase import tic_pkg::*; #(
  parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic signed [ANGLE_W-1:0] up_angle,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output logic [$clog2(TABLE_SIZE)-1:0] dn_index,
  output logic [FRACTION_BITS-1:0]  dn_frac
);

  localparam int IW = $clog2(TABLE_SIZE);

  logic                       a_valid;
  logic                       a_ready;
  logic [PHASE_W-1:0]         a_phase;
  logic signed [ANGLE_W+30:0] scaled;
  logic [PHASE_W-1:0]         phase_cos;
  logic [PHASE_W-1:0]         frac_word;
  logic                       b_ready;

  // Stage A: angle times 1/(2*pi); bits 47:16 are the phase, wrapping mod one turn
  assign scaled = up_angle * $signed({1'b0, TURN_SCALE});

  assign b_ready  = !dn_valid || dn_ready;
  assign a_ready  = !a_valid || b_ready;
  assign up_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && a_ready) begin
      a_phase <= scaled[47:16];
    end
  end

  // Stage B: add a quarter turn so the sine table gives cosine, then split
  assign phase_cos = a_phase + QUARTER_TURN;
  assign frac_word = phase_cos << IW;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (b_ready) begin
      dn_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && b_ready) begin
      dn_index <= phase_cos[PHASE_W-1 -: IW];
      dn_frac  <= frac_word[PHASE_W-1 -: FRACTION_BITS];
    end
  end

endmodule

// ===== src/tic_lookup.sv =====
// Table stage: reads the two adjacent sine entries from a folded quarter-wave table.
`timescale 1ns / 1ps

module tic_lookup import tic_pkg::*; #(
  parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [$clog2(TABLE_SIZE)-1:0] up_index,
  input  logic [FRACTION_BITS-1:0]      up_frac,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic signed [COS_W-1:0]       dn_lo,
  output logic signed [COS_W-1:0]       dn_hi,
  output logic [FRACTION_BITS-1:0]      dn_frac
);

  localparam int IW  = $clog2(TABLE_SIZE);
  localparam int QIW = IW - 1;
  localparam int QN  = TABLE_SIZE / 4 + 1;
  localparam logic [QIW-1:0] QUARTER_N = QIW'(TABLE_SIZE / 4);

  logic [15:0]             qtab [QN];
  logic [IW:0]             entry_n [2];
  logic signed [COS_W-1:0] entry_val [2];

  // Quarter-wave magnitudes, fixed at elaboration
  for (genvar g = 0; g < QN; g++) begin : g_qtab
    assign qtab[g] = qsine_q15(4 * g, IW);
  end

  assign entry_n[0] = {1'b0, up_index};
  assign entry_n[1] = {1'b0, up_index} + (IW+1)'(1);

  // Fold the full-wave entry number onto the quarter table, then sign and saturate
  for (genvar p = 0; p < 2; p++) begin : g_port
    logic [IW-3:0]  low;
    logic [QIW-1:0] m;
    logic [15:0]    mag;
    logic           neg;

    always_comb begin
      low = entry_n[p][IW-3:0];
      if (entry_n[p][IW]) begin
        m = '0;
      end else if (entry_n[p][IW-2]) begin
        m = QUARTER_N - {1'b0, low};
      end else begin
        m = {1'b0, low};
      end
      mag = qtab[m];
      neg = !entry_n[p][IW] && entry_n[p][IW-1];
      if (neg) begin
        entry_val[p] = $signed(16'(~mag + 16'd1));
      end else if (mag > Q15_MAX_POS) begin
        entry_val[p] = $signed(Q15_MAX_POS);
      end else begin
        entry_val[p] = $signed(mag);
      end
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_lo   <= entry_val[0];
      dn_hi   <= entry_val[1];
      dn_frac <= up_frac;
    end
  end

endmodule

// ===== src/tic_interp.sv =====
// Interpolation stages: weighted difference, floor shift and final add.
`timescale 1ns / 1ps

module tic_interp import tic_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic signed [COS_W-1:0] up_lo,
  input  logic signed [COS_W-1:0] up_hi,
  input  logic [FRACTION_BITS-1:0] up_frac,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic signed [COS_W-1:0] dn_cos
);

  localparam int PW = COS_W + FRACTION_BITS + 2;

  logic signed [COS_W:0]   diff;
  logic signed [PW-1:0]    weighted;
  logic                    c_valid;
  logic                    c_ready;
  logic signed [PW-1:0]    c_prod;
  logic signed [COS_W-1:0] c_lo;
  logic signed [PW-1:0]    step;
  logic                    d_ready;

  // Stage C: (b - a) * frac
  assign diff     = $signed({up_hi[COS_W-1], up_hi}) - $signed({up_lo[COS_W-1], up_lo});
  assign weighted = diff * $signed({1'b0, up_frac});

  assign d_ready  = !dn_valid || dn_ready;
  assign c_ready  = !c_valid || d_ready;
  assign up_ready = c_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && c_ready) begin
      c_prod <= weighted;
      c_lo   <= up_lo;
    end
  end

  // Stage D: arithmetic shift floors toward minus infinity; result lies between a and b
  assign step = c_prod >>> FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (d_ready) begin
      dn_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_valid && d_ready) begin
      dn_cos <= c_lo + step[COS_W-1:0];
    end
  end

endmodule

// ===== tb/tic_cos_checker.sv =====
// Checker for the table-interpolated cosine: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module tic_cos_checker import tic_pkg::*; #(
  parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  tic_angle_if angle,
  tic_cos_if   cosine,
  output int   fail_count,
  output int   pending,
  output int   result_count
);

  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic signed [ANGLE_W-1:0] angle_rad;
    logic signed [COS_W-1:0]   cos_value;
  } cos_due_t;

  // Full sine table, TABLE_SIZE+1 entries of Q1.15
  logic signed [COS_W-1:0] sine_tab [0:TABLE_SIZE];
  cos_due_t                cos_due [$];
  int                      fails = 0;
  int                      results = 0;

  // sin((pi/2) * num / TABLE_SIZE) in unsigned Q2.30, truncating Horner series
  function automatic logic [63:0] quarter_sine_q30(input logic [63:0] num);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sub;
    logic [63:0] d;
    int          k;
    x  = (HALF_PI_Q30 * num) / 64'(TABLE_SIZE);
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (k = 10; k >= 1; k--) begin
      d   = 64'(2 * k) * 64'(2 * k + 1);
      sub = ((x2 * t) >> 30) / d;
      t   = (sub < Q30_ONE) ? Q30_ONE - sub : 64'd0;
    end
    return (x * t) >> 30;
  endfunction

  // One table entry: quadrant fold, round half up to Q15, saturate
  function automatic logic signed [COS_W-1:0] sine_entry(input int n);
    logic [63:0] m;
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] s;
    m    = 64'(4 * n);
    quad = m / 64'(TABLE_SIZE);
    rem  = m % 64'(TABLE_SIZE);
    s    = quad[0] ? quarter_sine_q30(64'(TABLE_SIZE) - rem) : quarter_sine_q30(rem);
    s    = (s + 64'd16384) >> 15;
    if (quad == 2 || quad == 3) begin
      if (s > 64'(Q15_MAG_MAX)) s = 64'(Q15_MAG_MAX);
      s = -s;
    end else begin
      if (s > 64'(Q15_MAX_POS)) s = 64'(Q15_MAX_POS);
    end
    return s[COS_W-1:0];
  endfunction

  // Angle -> wrapped phase (+quarter turn) -> index/weight -> floored interpolation
  function automatic logic signed [COS_W-1:0] cos_of(input logic signed [ANGLE_W-1:0] a);
    longint             scaled;
    logic [PHASE_W-1:0] ph;
    logic [63:0]        p;
    logic [63:0]        frac;
    int                 idx;
    longint             lo;
    longint             hi;
    longint             prod;
    longint             sum;
    scaled = longint'(a) * longint'(TURN_SCALE);
    ph     = scaled[47:16] + QUARTER_TURN;
    p      = 64'(ph) * 64'(TABLE_SIZE);
    idx    = int'(p >> 32);
    if (idx >= TABLE_SIZE) idx = TABLE_SIZE - 1;
    frac = 64'(p[31:0]) >> (32 - FRACTION_BITS);
    lo   = longint'(sine_tab[idx]);
    hi   = longint'(sine_tab[idx + 1]);
    prod = (hi - lo) * longint'(frac);
    sum  = lo + (prod >>> FRACTION_BITS);
    return sum[COS_W-1:0];
  endfunction

  initial begin
    int n;
    for (n = 0; n <= TABLE_SIZE; n++) begin
      sine_tab[n] = sine_entry(n);
    end
  end

  // Compare each output transfer with the oldest prediction, then record new angles
  always @(posedge clk) begin
    cos_due_t head;
    cos_due_t item;
    if (!rst) begin
      if (cosine.valid && cosine.ready) begin
        results++;
        if (cos_due.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS) begin
            $display("%0t: unexpected cosine %0d, nothing pending", $realtime,
                     cosine.cos_value);
          end
        end else begin
          head = cos_due.pop_front();
          if (cosine.cos_value !== head.cos_value) begin
            fails++;
            if (fails <= MAX_REPORTS) begin
              $display("%0t: angle %0d: cos_value expected %0d got %0d", $realtime,
                       head.angle_rad, head.cos_value, cosine.cos_value);
            end
          end
        end
      end
      if (angle.valid && angle.ready) begin
        item.angle_rad = angle.angle_rad;
        item.cos_value = cos_of(angle.angle_rad);
        cos_due.push_back(item);
      end
    end
    fail_count   <= fails;
    result_count <= results;
    pending      <= cos_due.size();
  end

endmodule

// ===== tb/table_interp_cosine_tb.sv =====
// Testbench top for the table-interpolated cosine: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module table_interp_cosine_tb;
  import tic_pkg::*;

  localparam int N_CORNERS  = 20;
  localparam int HOLD_LEN   = 80;
  localparam int HALF_PI_16 = 102944;
  localparam int TWO_PI_16  = 411775;

  logic clk;
  logic rst;

  tic_angle_if angle_ch ();
  tic_cos_if   cos_ch ();

  int send_idle_pct;
  int recv_idle_pct;
  bit want_hold;
  int fail_count;
  int pending;
  int result_count;
  int angles_sent;

  // Corners: zero, +-1 LSB, full-scale, +-pi, +-pi/2, just past -pi/2 (phase near
  // one turn, last table pair), 3pi/2, +-2pi, mixed bit patterns, 1 rad
  logic signed [ANGLE_W-1:0] corner_angles [0:N_CORNERS-1] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
    32'sd205887, -32'sd205887, 32'sd102944, -32'sd102944, -32'sd102945,
    -32'sd102960, 32'sd308831, 32'sd411775, -32'sd411775, 32'sh0000_FFFF,
    32'shFFFF_0000, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd6434, 32'sh0001_0000
  };

  table_interp_cosine DUT (
    .clk    (clk),
    .rst    (rst),
    .angle  (angle_ch),
    .cosine (cos_ch)
  );

  tic_cos_checker chk (
    .clk          (clk),
    .rst          (rst),
    .angle        (angle_ch),
    .cosine       (cos_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    #400000;
    $display("run did not finish in time");
    $display("TB_ERROR");
    $finish;
  end

  // Mix of full-range words, angles within two turns, quarter-turn neighborhoods and small sign-extended angles
  function automatic logic signed [ANGLE_W-1:0] rand_angle();
    logic signed [ANGLE_W-1:0] a;
    logic [15:0]               low;
    case ($urandom_range(3))
      0: a = $urandom;
      1: a = int'($urandom_range(2 * TWO_PI_16)) - TWO_PI_16;
      2: a = HALF_PI_16 * (int'($urandom_range(16)) - 8) + int'($urandom_range(40)) - 20;
      default: begin
        low = 16'($urandom);
        a = {{16{low[15]}}, low};
      end
    endcase
    return a;
  endfunction

  // Offer one angle, with random gaps before it, and hold until the transfer
  task automatic send_angle(input logic signed [ANGLE_W-1:0] a);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      angle_ch.valid <= 1'b0;
      @(posedge clk);
    end
    angle_ch.valid     <= 1'b1;
    angle_ch.angle_rad <= a;
    @(posedge clk);
    while (!angle_ch.ready) @(posedge clk);
    angles_sent++;
  endtask

  // Output side: random back-pressure plus one long hold-off on request
  initial begin
    int  hold_left;
    bit  hold_taken;
    hold_left    = 0;
    hold_taken   = 0;
    cos_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (want_hold && !hold_taken) begin
        hold_taken = 1;
        hold_left  = HOLD_LEN;
      end
      if (hold_left > 0) begin
        cos_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        cos_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int i;
    rst                = 1'b1;
    angle_ch.valid     = 1'b0;
    angle_ch.angle_rad = '0;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    want_hold          = 0;
    angles_sent        = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Sender sparse, receiver sparser
    send_idle_pct = 36;
    recv_idle_pct = 61;
    for (i = 0; i < N_CORNERS; i++) begin
      send_angle(corner_angles[i]);
    end
    repeat (280) send_angle(rand_angle());

    // Swap the idling rates
    send_idle_pct = 61;
    recv_idle_pct = 36;
    repeat (280) send_angle(rand_angle());

    // Full rate, starting with a long output hold-off so the pipe fills
    send_idle_pct = 0;
    recv_idle_pct = 0;
    want_hold     = 1;
    repeat (270) send_angle(rand_angle());

    angle_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d angles (corners, full-range words, wrapped and quarter-turn angles)",
             angles_sent);
    $display("checked %0d cosines under three idling mixes and a %0d-cycle output hold",
             result_count, HOLD_LEN);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
